[sv/srhc_pkg.sv]
package srhc_pkg;

    localparam int RAMP_DEPTH = 2048;
    localparam int RAMP_AW = $clog2(RAMP_DEPTH);
    localparam logic [23:0] RAMP_LAST = 24'(RAMP_DEPTH - 1);
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    localparam logic [15:0] HOMING_PERIOD_RST = 16'd6000;
    localparam logic [15:0] HOMING_HIGH_RST = 16'd200;

    localparam logic CFG_HOMING_PERIOD = 1'b0;
    localparam logic CFG_HOMING_HIGH = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_HOME  = 2'd1,
        OP_MOVE  = 2'd2,
        OP_PULSE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STG_SEEK    = 2'd0,
        STG_MEASURE = 2'd1,
        STG_RETURN  = 2'd2
    } stage_t;

    typedef struct packed {
        op_t         operation;
        logic [10:0] table_index;
        logic [15:0] table_value;
        logic [23:0] move_steps;
        logic        move_direction;
        logic        left_switch;
        logic        right_switch;
    } cmd_t;

    typedef struct packed {
        logic        pulses_running;
        logic        drive_enable;
        logic        step_direction;
        logic [15:0] reload_value;
        logic [15:0] compare_value;
        logic        move_done;
        logic        homing_done;
        logic [1:0]  homing_stage;
        logic [23:0] measured_span;
    } res_t;

    typedef struct packed {
        logic [23:0] steps_done;
        logic [23:0] goal_steps;
    } fwd_t;

    function automatic logic [15:0] dec_sat16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd0 : v - 16'd1;
    endfunction

endpackage

[sv/srhc_cmd_if.sv]
interface srhc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [10:0] table_index;
    logic [15:0] table_value;
    logic [23:0] move_steps;
    logic        move_direction;
    logic        left_switch;
    logic        right_switch;

    modport source (
        output valid, operation, table_index, table_value, move_steps,
               move_direction, left_switch, right_switch,
        input  ready
    );
    modport sink (
        input  valid, operation, table_index, table_value, move_steps,
               move_direction, left_switch, right_switch,
        output ready
    );
endinterface

[sv/srhc_res_if.sv]
interface srhc_res_if;
    logic        valid;
    logic        ready;
    logic        pulses_running;
    logic        drive_enable;
    logic        step_direction;
    logic [15:0] reload_value;
    logic [15:0] compare_value;
    logic        move_done;
    logic        homing_done;
    logic [1:0]  homing_stage;
    logic [23:0] measured_span;

    modport source (
        output valid, pulses_running, drive_enable, step_direction, reload_value,
               compare_value, move_done, homing_done, homing_stage, measured_span,
        input  ready
    );
    modport sink (
        input  valid, pulses_running, drive_enable, step_direction, reload_value,
               compare_value, move_done, homing_done, homing_stage, measured_span,
        output ready
    );
endinterface

[sv/srhc_ramp_mem.sv]
module srhc_ramp_mem
    import srhc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [RAMP_AW-1:0] addr,
    input  logic [15:0]        wdata,
    output logic [15:0]        rdata
);

    logic [15:0] ram [RAMP_DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                ram[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= ram[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/srhc_ctrl.sv]
module srhc_ctrl
    import srhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  cmd_t        item,
    input  logic [15:0] rdata,
    input  logic [15:0] homing_period,
    input  logic [15:0] homing_high_time,
    output res_t        result,
    output fwd_t        fwd
);

    logic        homing_active_reg, homing_active_next;
    stage_t      stage_reg, stage_next;
    logic [23:0] span_count_reg, span_count_next;
    logic        returning_reg, returning_next;
    logic        moving_reg, moving_next;
    logic [23:0] steps_done_reg, steps_done_next;
    logic [23:0] goal_steps_reg, goal_steps_next;
    logic        direction_reg, direction_next;
    logic        running_reg, running_next;
    logic        enabled_reg, enabled_next;
    logic [15:0] reload_reg, reload_next;
    logic [15:0] compare_reg, compare_next;
    logic        mdone, hdone;
    logic [15:0] per;

    always_comb
    begin
        homing_active_next = homing_active_reg;
        stage_next         = stage_reg;
        span_count_next    = span_count_reg;
        returning_next     = returning_reg;
        moving_next        = moving_reg;
        steps_done_next    = steps_done_reg;
        goal_steps_next    = goal_steps_reg;
        direction_next     = direction_reg;
        running_next       = running_reg;
        enabled_next       = enabled_reg;
        reload_next        = reload_reg;
        compare_next       = compare_reg;
        mdone              = 1'b0;
        hdone              = 1'b0;
        per                = dec_sat16(rdata);
        if (adv)
        begin
            unique case (item.operation)
                OP_LOAD:
                begin
                end
                OP_HOME:
                begin
                    homing_active_next = 1'b1;
                    returning_next     = 1'b0;
                    moving_next        = 1'b0;
                    stage_next         = STG_SEEK;
                    span_count_next    = 24'd0;
                    direction_next     = 1'b0;
                    reload_next        = dec_sat16(homing_period);
                    compare_next       = dec_sat16(homing_high_time);
                    enabled_next       = 1'b1;
                    running_next       = 1'b1;
                end
                OP_MOVE:
                begin
                    homing_active_next = 1'b0;
                    returning_next     = 1'b0;
                    moving_next        = 1'b1;
                    goal_steps_next    = item.move_steps;
                    steps_done_next    = 24'd0;
                    direction_next     = item.move_direction;
                    reload_next        = dec_sat16(rdata);
                    compare_next       = rdata >> 1;
                    enabled_next       = 1'b1;
                    running_next       = 1'b1;
                end
                OP_PULSE:
                begin
                    if (running_reg)
                    begin
                        if (homing_active_reg)
                        begin
                            if (span_count_next != COUNT_MAX)
                            begin
                                span_count_next = span_count_next + 24'd1;
                            end
                            if (!item.left_switch)
                            begin
                                direction_next = 1'b1;
                                if (stage_reg == STG_SEEK)
                                begin
                                    stage_next      = STG_MEASURE;
                                    span_count_next = 24'd0;
                                end
                            end
                            else if (!item.right_switch)
                            begin
                                direction_next = 1'b0;
                                if (stage_reg == STG_MEASURE)
                                begin
                                    stage_next         = STG_RETURN;
                                    homing_active_next = 1'b0;
                                    returning_next     = 1'b1;
                                    steps_done_next    = 24'd0;
                                end
                            end
                            reload_next  = dec_sat16(homing_period);
                            enabled_next = 1'b1;
                        end
                        if (returning_next)
                        begin
                            if (steps_done_next != COUNT_MAX)
                            begin
                                steps_done_next = steps_done_next + 24'd1;
                            end
                            if (steps_done_next >= (span_count_next >> 1))
                            begin
                                returning_next = 1'b0;
                                running_next   = 1'b0;
                                enabled_next   = 1'b0;
                                hdone          = 1'b1;
                            end
                        end
                        if (moving_reg)
                        begin
                            if (steps_done_next != COUNT_MAX)
                            begin
                                steps_done_next = steps_done_next + 24'd1;
                            end
                            if (!item.left_switch)
                            begin
                                direction_next = 1'b1;
                            end
                            else if (!item.right_switch)
                            begin
                                direction_next = 1'b0;
                            end
                            if (steps_done_next >= goal_steps_reg)
                            begin
                                moving_next  = 1'b0;
                                running_next = 1'b0;
                                enabled_next = 1'b0;
                                mdone        = 1'b1;
                            end
                            else
                            begin
                                reload_next  = dec_sat16(per);
                                compare_next = dec_sat16(per >> 1);
                                enabled_next = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_active_reg <= 1'b0;
            stage_reg         <= STG_SEEK;
            span_count_reg    <= 24'd0;
            returning_reg     <= 1'b0;
            moving_reg        <= 1'b0;
            steps_done_reg    <= 24'd0;
            goal_steps_reg    <= 24'd0;
            direction_reg     <= 1'b0;
            running_reg       <= 1'b0;
            enabled_reg       <= 1'b0;
            reload_reg        <= 16'd0;
            compare_reg       <= 16'd0;
        end
        else
        begin
            homing_active_reg <= homing_active_next;
            stage_reg         <= stage_next;
            span_count_reg    <= span_count_next;
            returning_reg     <= returning_next;
            moving_reg        <= moving_next;
            steps_done_reg    <= steps_done_next;
            goal_steps_reg    <= goal_steps_next;
            direction_reg     <= direction_next;
            running_reg       <= running_next;
            enabled_reg       <= enabled_next;
            reload_reg        <= reload_next;
            compare_reg       <= compare_next;
        end
    end

    assign result = '{
        pulses_running: running_next,
        drive_enable:   enabled_next,
        step_direction: direction_next,
        reload_value:   reload_next,
        compare_value:  compare_next,
        move_done:      mdone,
        homing_done:    hdone,
        homing_stage:   stage_next,
        measured_span:  span_count_next
    };

    assign fwd = '{steps_done: steps_done_next, goal_steps: goal_steps_next};

endmodule

[sv/stepper_ramp_homing_controller_core.sv]
// Each command is registered into a buffer stage, then its result into an output
// register; a stall on the result side holds both stages.
// Throughput: one command per cycle unless results stall; the ramp table read
// is issued on transfer; it updates on advance, with step count forwarded.
// Reset: homing period 6000 and high time 200, motion state cleared, outputs idle.
// Ramp table contents are undefined until loaded.
module stepper_ramp_homing_controller_core
    import srhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    srhc_cmd_if.sink    cmd,
    srhc_res_if.source  res
);

    logic [15:0]        homing_period_reg;
    logic [15:0]        homing_high_reg;
    logic               b_valid_reg;
    cmd_t               b_cmd_reg;
    logic               res_valid_reg;
    res_t               res_data_reg;
    cmd_t               cmd_in;
    logic               cmd_fire;
    logic               b_adv;
    res_t               result;
    fwd_t               fwd;
    logic [15:0]        rdata;
    logic [RAMP_AW-1:0] mem_addr;
    logic               mem_we;
    logic [23:0]        s_inc;
    logic [23:0]        remain;
    logic [23:0]        near;

    assign cmd_in = '{
        operation:      op_t'(cmd.operation),
        table_index:    cmd.table_index,
        table_value:    cmd.table_value,
        move_steps:     cmd.move_steps,
        move_direction: cmd.move_direction,
        left_switch:    cmd.left_switch,
        right_switch:   cmd.right_switch
    };

    assign b_adv     = b_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !b_valid_reg || b_adv;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_period_reg <= HOMING_PERIOD_RST;
            homing_high_reg   <= HOMING_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            priority if (cfg_index == CFG_HOMING_PERIOD)
            begin
                homing_period_reg <= cfg_wdata;
            end
            else if (cfg_index == CFG_HOMING_HIGH)
            begin
                homing_high_reg <= cfg_wdata;
            end
        end
    end

    // ramp index for the next step, from step count after any update in flight
    always_comb
    begin
        s_inc  = (fwd.steps_done == COUNT_MAX) ? fwd.steps_done : fwd.steps_done + 24'd1;
        remain = fwd.goal_steps - s_inc;
        near   = (s_inc < remain) ? s_inc : remain;
        mem_we = 1'b0;
        unique case (cmd_in.operation)
            OP_LOAD:
            begin
                mem_addr = RAMP_AW'(cmd_in.table_index);
                mem_we   = 32'(cmd_in.table_index) < RAMP_DEPTH;
            end
            OP_MOVE:
            begin
                mem_addr = '0;
            end
            OP_HOME, OP_PULSE:
            begin
                mem_addr = (near >= RAMP_LAST) ? RAMP_AW'(RAMP_LAST) : RAMP_AW'(near);
            end
        endcase
    end

    srhc_ramp_mem u_ramp_mem (
        .clk   (clk),
        .en    (cmd_fire),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (cmd_in.table_value),
        .rdata (rdata)
    );

    srhc_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (b_adv),
        .item             (b_cmd_reg),
        .rdata            (rdata),
        .homing_period    (homing_period_reg),
        .homing_high_time (homing_high_reg),
        .result           (result),
        .fwd              (fwd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            b_cmd_reg <= cmd_in;
        end
        if (b_adv)
        begin
            res_data_reg <= result;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.pulses_running = res_data_reg.pulses_running;
    assign res.drive_enable   = res_data_reg.drive_enable;
    assign res.step_direction = res_data_reg.step_direction;
    assign res.reload_value   = res_data_reg.reload_value;
    assign res.compare_value  = res_data_reg.compare_value;
    assign res.move_done      = res_data_reg.move_done;
    assign res.homing_done    = res_data_reg.homing_done;
    assign res.homing_stage   = res_data_reg.homing_stage;
    assign res.measured_span  = res_data_reg.measured_span;

endmodule

[sv/srhc_checker.sv]
module srhc_checker
    import srhc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        pulses_running,
    input logic        drive_enable,
    input logic        move_done,
    input logic        homing_done,
    input logic [1:0]  homing_stage,
    input logic [15:0] reload_value,
    input logic [15:0] compare_value
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(reload_value)
            && $stable(compare_value))
        else $error("result changed while stalled");

    a_enable_tracks_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pulses_running == drive_enable)
        else $error("driver enable differs from pulse run state");

    a_move_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && move_done |-> !pulses_running && !homing_done)
        else $error("move done while pulses still running");

    a_home_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && homing_done |-> !pulses_running && homing_stage == STG_RETURN)
        else $error("homing done outside return stage");

endmodule

bind stepper_ramp_homing_controller_core srhc_checker u_srhc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .pulses_running (res.pulses_running),
    .drive_enable   (res.drive_enable),
    .move_done      (res.move_done),
    .homing_done    (res.homing_done),
    .homing_stage   (res.homing_stage),
    .reload_value   (res.reload_value),
    .compare_value  (res.compare_value)
);

[tb/sv/tb_stepper_ramp_homing_controller_core.sv]
`timescale 1ns / 100ps

module tb_stepper_ramp_homing_controller_core;
    import srhc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 60;

    class stepper_board;
        logic [15:0] ramp_mem [RAMP_DEPTH];
        bit          loaded [RAMP_DEPTH];
        logic [15:0] period_reg;
        logic [15:0] high_reg;
        bit          homing;
        bit          ret;
        bit          moving;
        bit          run;
        bit          en;
        logic        dir;
        stage_t      stg;
        logic [23:0] span;
        logic [23:0] steps;
        logic [23:0] goal;
        logic [15:0] reload;
        logic [15:0] compare;
        res_t        expected_reports [$];
        int          errors;

        function new();
            period_reg = HOMING_PERIOD_RST;
            high_reg = HOMING_HIGH_RST;
            homing = 0;
            ret = 0;
            moving = 0;
            run = 0;
            en = 0;
            dir = 1'b0;
            stg = STG_SEEK;
            span = '0;
            steps = '0;
            goal = '0;
            reload = '0;
            compare = '0;
            errors = 0;
        endfunction

        function logic [15:0] minus_one(logic [15:0] v);
            return (v == 16'd0) ? 16'd0 : v - 16'd1;
        endfunction

        // Table entry the next step pulse of a move reads, -1 if none.
        function int next_ramp_index();
            logic [23:0] s;
            logic [23:0] b;
            logic [23:0] m;
            if (!(run && moving))
                return -1;
            s = (steps == COUNT_MAX) ? steps : steps + 24'd1;
            if (s >= goal)
                return -1;
            b = goal - s;
            m = (s < b) ? s : b;
            if (m > RAMP_LAST)
                m = RAMP_LAST;
            return int'(m);
        endfunction

        function void record_command(cmd_t c);
            res_t        r;
            logic [15:0] t0;
            logic [15:0] per;
            int          idx;
            bit          mdone;
            bit          hdone;
            mdone = 0;
            hdone = 0;
            case (c.operation)
                OP_LOAD:
                begin
                    ramp_mem[c.table_index] = c.table_value;
                    loaded[c.table_index] = 1;
                end
                OP_HOME:
                begin
                    homing = 1;
                    ret = 0;
                    moving = 0;
                    stg = STG_SEEK;
                    span = '0;
                    dir = 1'b0;
                    reload = minus_one(period_reg);
                    compare = minus_one(high_reg);
                    en = 1;
                    run = 1;
                end
                OP_MOVE:
                begin
                    t0 = ramp_mem[0];
                    homing = 0;
                    ret = 0;
                    moving = 1;
                    goal = c.move_steps;
                    steps = '0;
                    dir = c.move_direction;
                    reload = minus_one(t0);
                    compare = t0 >> 1;
                    en = 1;
                    run = 1;
                end
                default:
                begin
                    idx = next_ramp_index();
                    if (run)
                    begin
                        if (homing)
                        begin
                            if (span != COUNT_MAX)
                                span++;
                            if (!c.left_switch)
                            begin
                                dir = 1'b1;
                                if (stg == STG_SEEK)
                                begin
                                    stg = STG_MEASURE;
                                    span = '0;
                                end
                            end
                            else if (!c.right_switch)
                            begin
                                dir = 1'b0;
                                if (stg == STG_MEASURE)
                                begin
                                    stg = STG_RETURN;
                                    homing = 0;
                                    ret = 1;
                                    steps = '0;
                                end
                            end
                            reload = minus_one(period_reg);
                            en = 1;
                        end
                        if (ret)
                        begin
                            if (steps != COUNT_MAX)
                                steps++;
                            if (steps >= (span >> 1))
                            begin
                                ret = 0;
                                run = 0;
                                en = 0;
                                hdone = 1;
                            end
                        end
                        if (moving)
                        begin
                            if (steps != COUNT_MAX)
                                steps++;
                            per = 16'd0;
                            if (idx >= 0)
                                per = minus_one(ramp_mem[idx]);
                            if (!c.left_switch)
                                dir = 1'b1;
                            else if (!c.right_switch)
                                dir = 1'b0;
                            if (idx < 0)
                            begin
                                moving = 0;
                                run = 0;
                                en = 0;
                                mdone = 1;
                            end
                            else
                            begin
                                reload = minus_one(per);
                                compare = minus_one(per >> 1);
                                en = 1;
                            end
                        end
                    end
                end
            endcase
            r.pulses_running = run;
            r.drive_enable = en;
            r.step_direction = dir;
            r.reload_value = reload;
            r.compare_value = compare;
            r.move_done = mdone;
            r.homing_done = hdone;
            r.homing_stage = stg;
            r.measured_span = span;
            expected_reports.push_back(r);
        endfunction

        function void cmp(string name, logic [23:0] exp_v, logic [23:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s expected %0h got %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_report(res_t got);
            res_t e;
            if (expected_reports.size() == 0)
            begin
                $error("result transfer with no pending command");
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            cmp("pulses_running", e.pulses_running, got.pulses_running);
            cmp("drive_enable", e.drive_enable, got.drive_enable);
            cmp("step_direction", e.step_direction, got.step_direction);
            cmp("reload_value", e.reload_value, got.reload_value);
            cmp("compare_value", e.compare_value, got.compare_value);
            cmp("move_done", e.move_done, got.move_done);
            cmp("homing_done", e.homing_done, got.homing_done);
            cmp("homing_stage", e.homing_stage, got.homing_stage);
            cmp("measured_span", e.measured_span, got.measured_span);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    bit          idle_on;
    int          active_items;
    int          cycles;

    stepper_board board = new();

    srhc_cmd_if cmd_ch ();
    srhc_res_if res_ch ();

    stepper_ramp_homing_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_stepper_ramp_homing_controller_core failed");
        $finish;
    end

    // result side: check at rising edge, stall bursts driven at falling edge
    initial
    begin
        int   stall;
        res_t got;
        stall = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.pulses_running = res_ch.pulses_running;
                got.drive_enable = res_ch.drive_enable;
                got.step_direction = res_ch.step_direction;
                got.reload_value = res_ch.reload_value;
                got.compare_value = res_ch.compare_value;
                got.move_done = res_ch.move_done;
                got.homing_done = res_ch.homing_done;
                got.homing_stage = res_ch.homing_stage;
                got.measured_span = res_ch.measured_span;
                board.check_report(got);
            end
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(0, 5);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    function automatic cmd_t rand_cmd(op_t op);
        cmd_t c;
        c.operation = op;
        c.table_index = 11'($urandom);
        c.table_value = 16'($urandom);
        c.move_steps = 24'($urandom);
        c.move_direction = 1'($urandom);
        c.left_switch = ($urandom_range(0, 7) != 0);
        c.right_switch = ($urandom_range(0, 7) != 0);
        return c;
    endfunction

    task automatic push_cmd(input cmd_t c);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.operation <= c.operation;
        cmd_ch.table_index <= c.table_index;
        cmd_ch.table_value <= c.table_value;
        cmd_ch.move_steps <= c.move_steps;
        cmd_ch.move_direction <= c.move_direction;
        cmd_ch.left_switch <= c.left_switch;
        cmd_ch.right_switch <= c.right_switch;
        cmd_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        board.record_command(c);
    endtask

    // loads any not yet loaded ramp entry the command is about to read, then sends it
    task automatic issue(input cmd_t c);
        cmd_t ld;
        int   idx;
        idx = -1;
        if (c.operation == OP_MOVE && !board.loaded[0])
            idx = 0;
        else if (c.operation == OP_PULSE)
            idx = board.next_ramp_index();
        if (idx >= 0 && !board.loaded[idx])
        begin
            ld = rand_cmd(OP_LOAD);
            ld.table_index = 11'(idx);
            push_cmd(ld);
        end
        if (!(c.operation == OP_PULSE && !board.run))
            active_items++;
        push_cmd(c);
    endtask

    task automatic do_load(input int idx, input logic [15:0] value);
        cmd_t c;
        c = rand_cmd(OP_LOAD);
        c.table_index = 11'(idx);
        c.table_value = value;
        issue(c);
    endtask

    task automatic do_move(input logic [23:0] goal, input logic dir);
        cmd_t c;
        c = rand_cmd(OP_MOVE);
        c.move_steps = goal;
        c.move_direction = dir;
        issue(c);
    endtask

    task automatic do_home();
        issue(rand_cmd(OP_HOME));
    endtask

    task automatic do_pulse(input logic left, input logic right);
        cmd_t c;
        c = rand_cmd(OP_PULSE);
        c.left_switch = left;
        c.right_switch = right;
        issue(c);
    endtask

    task automatic settle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (board.expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] period, input logic [15:0] high);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HOMING_PERIOD;
        cfg_wdata <= period;
        @(negedge clk);
        cfg_index <= CFG_HOMING_HIGH;
        cfg_wdata <= high;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.period_reg = period;
        board.high_reg = high;
    endtask

    task automatic homing_sequence();
        int n;
        int guard;
        do_home();
        repeat ($urandom_range(0, 4))
            do_pulse(1'b1, $urandom_range(0, 3) != 0);
        do_pulse(1'b0, 1'($urandom));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 30);
        repeat (n)
            do_pulse($urandom_range(0, 9) != 0, 1'b1);
        if ($urandom_range(0, 7) == 0)
        begin
            do_move(24'($urandom_range(0, 20)), 1'($urandom));
            return;
        end
        do_pulse(1'b1, 1'b0);
        guard = 0;
        while (board.run && guard < 300)
        begin
            do_pulse($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            guard++;
        end
    endtask

    task automatic move_sequence();
        logic [23:0] goal;
        int          sel;
        int          limit;
        int          i;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            goal = 24'($urandom_range(0, 40));
        else if (sel < 9)
            goal = 24'($urandom_range(41, 300));
        else
            goal = 24'($urandom);
        do_move(goal, 1'($urandom));
        limit = (sel == 9) ? $urandom_range(1, 20) : int'(goal) + 1;
        if ($urandom_range(0, 9) == 0)
            limit = $urandom_range(0, limit);
        i = 0;
        while (board.run && i < limit)
        begin
            do_pulse($urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
            i++;
        end
    endtask

    task automatic random_phase(input int budget);
        int   stop_at;
        int   sel;
        logic [15:0] v;
        stop_at = active_items + budget;
        while (active_items < stop_at)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                homing_sequence();
            else if (sel < 8)
                move_sequence();
            else if (sel == 8)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 5))
                        0: v = 16'd0;
                        1: v = 16'd1;
                        2: v = 16'hFFFF;
                        default: v = 16'($urandom);
                    endcase
                    do_load($urandom_range(0, RAMP_DEPTH - 1), v);
                end
            end
            else
                repeat ($urandom_range(1, 6))
                    issue(rand_cmd(op_t'($urandom_range(0, 3))));
        end
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_HOMING_PERIOD;
        cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.operation = '0;
        cmd_ch.table_index = '0;
        cmd_ch.table_value = '0;
        cmd_ch.move_steps = '0;
        cmd_ch.move_direction = 1'b0;
        cmd_ch.left_switch = 1'b1;
        cmd_ch.right_switch = 1'b1;
        idle_on = 1;
        active_items = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pulse while idle is ignored
        do_pulse(1'b0, 1'b0);
        do_load(0, 16'h0FA0);
        do_load(1, 16'h0000);
        do_load(2, 16'h0001);
        do_load(RAMP_DEPTH - 1, 16'hFFFF);
        // zero and one step moves stop on the first pulse
        do_move(24'd0, 1'b1);
        do_pulse(1'b1, 1'b1);
        do_move(24'd1, 1'b0);
        do_pulse(1'b0, 1'b1);
        // short ramp with saturating periods, both switches pressed
        do_move(24'd4, 1'b0);
        do_pulse(1'b1, 1'b0);
        do_pulse(1'b0, 1'b0);
        do_pulse(1'b1, 1'b1);
        do_pulse(1'b1, 1'b1);
        do_move(COUNT_MAX, 1'b1);
        do_pulse(1'b1, 1'b1);
        // homing aborts move; span of one returns at once
        do_home();
        do_pulse(1'b1, 1'b0);
        do_pulse(1'b0, 1'b1);
        do_pulse(1'b1, 1'b0);
        do_pulse(1'b1, 1'b1);
        do_home();
        do_pulse(1'b0, 1'b1);
        do_move(24'd2, 1'b0);
        do_pulse(1'b1, 1'b1);
        do_pulse(1'b1, 1'b1);

        for (phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                case (phase)
                    1: write_regs(16'd1, 16'hFFFF);
                    2: write_regs(16'hFFFF, 16'd1);
                    default: write_regs(16'($urandom_range(1, 65535)),
                                        16'($urandom_range(1, 65535)));
                endcase
            end
            if (phase == 4)
                idle_on = 0;
            random_phase(PHASE_ITEMS);
        end

        settle();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.expected_reports.size() == 0)
            $display("tb_stepper_ramp_homing_controller_core passed");
        else
            $display("tb_stepper_ramp_homing_controller_core failed");
        $finish;
    end

endmodule
